// ===== hdl/pvl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the phong vertex lighting pipeline
// no dependencies; imported by pvl_norm, pvl_pow and phong_vertex_lighting
package pvl_pkg;

    typedef enum logic [2:0] {
        REG_AMBIENT_COEFF   = 3'd0,
        REG_DIFFUSE_COEFF   = 3'd1,
        REG_SPECULAR_COEFF  = 3'd2,
        REG_AMBIENT_LIGHT   = 3'd3,
        REG_LIGHT_INTENSITY = 3'd4,
        REG_LIGHT_POSITION  = 3'd5,
        REG_VIEW_DIRECTION  = 3'd6,
        REG_SHININESS       = 3'd7
    } cfg_reg_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_W      = 48;
    localparam int LANE_W     = 16;
    localparam int SHINE_W    = 10;
    // light minus point, Q12.4 with one guard bit
    localparam int DIFF_W     = 17;
    localparam int MAG_W      = 16;
    // squared distance and its scaled square root
    localparam int SQ_W       = 34;
    localparam int ROOT_W     = 25;
    // per-channel term widths
    localparam int AMB_W      = 17;
    localparam int TERM_W     = 20;
    localparam int TOTAL_W    = 21;

    localparam logic [CFG_W-1:0]   VIEW_RESET  = 48'h0000_0000_8000;
    localparam logic [SHINE_W-1:0] SHINE_RESET = 10'd300;
    localparam logic [LANE_W-1:0]  OUT_MAX     = 16'd32768;

    // lane 0 is x or red in bits 47:32, lane 2 is z or blue in bits 15:0
    function automatic logic [LANE_W-1:0] lane_of(input logic [CFG_W-1:0] p, input int c);
        return p[LANE_W*(2-c) +: LANE_W];
    endfunction

endpackage

// ===== hdl/phong_vertex_lighting.sv =====
`timescale 1ns / 1ps
// per-vertex phong lighting with one point light, fixed point
// depends on pvl_pkg, pvl_norm (light vector) and pvl_pow (specular power)
//
// usage:
//   input beats carry a vertex position (Q12.4) and a unit normal (Q1.15) on
//   s_tdata; output beats carry clamped r,g,b intensities (Q1.15) on m_tdata.
//   registers are written through cfg_we/cfg_addr/cfg_data; the user must write
//   them only while the pipeline is empty, the block itself does not enforce this.
//   throughput is one vertex per clock while the output is not held. the
//   pipeline has 25 square-root stages, FRACTION_BITS + 3 divider and sign
//   stages, 20 exponent stages and 12 arithmetic stages.
//   every stage has a valid bit; when m_tvalid is high and m_tready is low the
//   whole pipeline holds and s_tready drops, so no beat is lost or repeated.
//   reset (rst_n low, asynchronous) empties the pipeline and loads the
//   register defaults: all zero except the view vector (0,0,-1.0) and an
//   exponent of 300.
module phong_vertex_lighting #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pvl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pvl_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z
    input  logic [6*pvl_pkg::LANE_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // intensity_red, intensity_green, intensity_blue
    output logic [3*pvl_pkg::LANE_W-1:0]    m_tdata
);
    import pvl_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int UW = F + 2;
    localparam int DW = F + 3;
    localparam int RW = F + 5;
    localparam int PSIDE_W = DW + 1;
    localparam logic signed [UW-1:0]  ONE_U   = UW'(1) << F;
    localparam logic [F:0]            ONE_P   = (F+1)'(1) << F;
    localparam logic signed [F+19:0]  HALF_E  = (F+20)'(1) << 14;
    localparam logic signed [F+20:0]  HALF_G  = (F+21)'(1) << 14;
    localparam logic signed [F+22:0]  HALF_I  = (F+23)'(1) << 14;
    localparam logic signed [F+7:0]   ONE_VR  = (F+8)'(1) << F;
    localparam logic [F+34:0]         HALF_K  = (F+35)'(1) << (F + 14);

    // configuration registers
    logic [CFG_W-1:0]   amb_coeff_reg, dif_coeff_reg, spec_coeff_reg;
    logic [CFG_W-1:0]   amb_light_reg, light_int_reg, light_pos_reg, view_dir_reg;
    logic [SHINE_W-1:0] shine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_coeff_reg  <= '0;
            dif_coeff_reg  <= '0;
            spec_coeff_reg <= '0;
            amb_light_reg  <= '0;
            light_int_reg  <= '0;
            light_pos_reg  <= '0;
            view_dir_reg   <= VIEW_RESET;
            shine_reg      <= SHINE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_AMBIENT_COEFF:   amb_coeff_reg  <= cfg_data;
                REG_DIFFUSE_COEFF:   dif_coeff_reg  <= cfg_data;
                REG_SPECULAR_COEFF:  spec_coeff_reg <= cfg_data;
                REG_AMBIENT_LIGHT:   amb_light_reg  <= cfg_data;
                REG_LIGHT_INTENSITY: light_int_reg  <= cfg_data;
                REG_LIGHT_POSITION:  light_pos_reg  <= cfg_data;
                REG_VIEW_DIRECTION:  view_dir_reg   <= cfg_data;
                REG_SHININESS:       shine_reg      <= cfg_data[SHINE_W-1:0];
                default: ;
            endcase
        end
    end

    // per-channel products of the registers, refreshed every cycle
    logic [31:0]      kaia_next [3];
    logic [32:0]      amb_rnd [3];
    logic [AMB_W-1:0] amb_reg [3];
    logic [31:0]      kdil_reg [3], kdil_next [3];
    logic [31:0]      ksil_reg [3], ksil_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            kaia_next[c] = lane_of(amb_coeff_reg, c) * lane_of(amb_light_reg, c);
            amb_rnd[c]   = 33'(kaia_next[c]) + 33'd16384;
            kdil_next[c] = lane_of(dif_coeff_reg, c) * lane_of(light_int_reg, c);
            ksil_next[c] = lane_of(spec_coeff_reg, c) * lane_of(light_int_reg, c);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            amb_reg[c]  <= amb_rnd[c][15 +: AMB_W];
            kdil_reg[c] <= kdil_next[c];
            ksil_reg[c] <= ksil_next[c];
        end
    end

    // pipeline enable: everything moves unless the output beat is held
    logic en;
    logic vl_reg;

    assign en       = m_tready || !vl_reg;
    assign s_tready = en;

    // stage a: light minus point
    logic signed [LANE_W-1:0] lp_l [3], pt_l [3], v_l [3];
    logic signed [DIFF_W-1:0] d_a_next [3], d_a_reg [3];
    logic signed [LANE_W-1:0] n_a_reg [3];
    logic                     va_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lp_l[i]     = $signed(lane_of(light_pos_reg, i));
            v_l[i]      = $signed(lane_of(view_dir_reg, i));
            pt_l[i]     = $signed(s_tdata[LANE_W*i +: LANE_W]);
            d_a_next[i] = lp_l[i] - pt_l[i];
        end
    end

    // stage b: squares
    logic signed [2*DIFF_W-1:0] dsq_b_next [3], dsq_b_reg [3];
    logic signed [DIFF_W-1:0]   d_b_reg [3];
    logic signed [LANE_W-1:0]   n_b_reg [3];
    logic                       vb_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dsq_b_next[i] = d_a_reg[i] * d_a_reg[i];
    end

    // stage c: squared distance
    logic [SQ_W-1:0]          sq_c_next, sq_c_reg;
    logic signed [DIFF_W-1:0] d_c_reg [3];
    logic signed [LANE_W-1:0] n_c_reg [3];
    logic                     vc_reg;

    assign sq_c_next = dsq_b_reg[0] + dsq_b_reg[1] + dsq_b_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_a_reg[i]   <= d_a_next[i];
                n_a_reg[i]   <= $signed(s_tdata[3*LANE_W + LANE_W*i +: LANE_W]);
                dsq_b_reg[i] <= dsq_b_next[i];
                d_b_reg[i]   <= d_a_reg[i];
                n_b_reg[i]   <= n_a_reg[i];
                d_c_reg[i]   <= d_b_reg[i];
                n_c_reg[i]   <= n_b_reg[i];
            end
            sq_c_reg <= sq_c_next;
        end
    end

    // unit light vector
    logic                   u_valid;
    logic signed [UW-1:0]   u_n [3];
    logic [3*LANE_W-1:0]    n_side;

    pvl_norm #(
        .FRAC   (F),
        .SIDE_W (3*LANE_W)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .sq        (sq_c_reg),
        .d         (d_c_reg),
        .side_in   ({n_c_reg[2], n_c_reg[1], n_c_reg[0]}),
        .out_valid (u_valid),
        .u         (u_n),
        .side_out  (n_side)
    );

    // stage d: n_i * l_i
    logic signed [LANE_W-1:0] n_l [3];
    logic signed [F+17:0]     nu_d_next [3], nu_d_reg [3];
    logic signed [LANE_W-1:0] n_d_reg [3], n_e_reg [3];
    logic signed [UW-1:0]     u_d_reg [3], u_e_reg [3], u_f_reg [3];
    logic                     vd_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_l[i]       = $signed(n_side[LANE_W*i +: LANE_W]);
            nu_d_next[i] = n_l[i] * u_n[i];
        end
    end

    // stage e: n.l
    logic signed [F+19:0] sum_e, tmp_e;
    logic signed [DW-1:0] dnl_e_reg;
    logic                 ve_reg;

    assign sum_e = nu_d_reg[0] + nu_d_reg[1] + nu_d_reg[2];
    assign tmp_e = sum_e + HALF_E;

    // stage f: (n.l) * n_i
    logic signed [F+18:0] m_f_next [3], m_f_reg [3];
    logic signed [DW-1:0] dnl_f_reg;
    logic                 vf_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            m_f_next[i] = dnl_e_reg * n_e_reg[i];
    end

    // stage g: reflection r = 2(n.l)n - l
    logic signed [F+20:0] t_g [3];
    logic signed [F+3:0]  rr_g [3];
    logic signed [RW-1:0] r_g_next [3], r_g_reg [3];
    logic signed [DW-1:0] dnl_g_reg;
    logic                 vg_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_g[i]      = m_f_reg[i] + m_f_reg[i] + HALF_G;
            rr_g[i]     = t_g[i][15 +: F+4];
            r_g_next[i] = rr_g[i] - u_f_reg[i];
        end
    end

    // stage h: v_i * r_i
    logic signed [F+20:0] vr_h_next [3], vr_h_reg [3];
    logic signed [DW-1:0] dnl_h_reg;
    logic                 vh_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            vr_h_next[i] = v_l[i] * r_g_reg[i];
    end

    // stage i: v.r, base of the power
    logic signed [F+22:0] sum_i;
    logic signed [F+7:0]  vr_i;
    logic [F:0]           base_i_next, base_i_reg;
    logic                 neg_i_reg;
    logic signed [DW-1:0] dnl_i_reg;
    logic                 vi_reg;

    assign sum_i = vr_h_reg[0] + vr_h_reg[1] + vr_h_reg[2] + HALF_I;
    assign vr_i  = sum_i[15 +: F+8];

    always_comb
    begin
        if (vr_i < 0)
            base_i_next = '0;
        else if (vr_i > ONE_VR)
            base_i_next = ONE_P;
        else
            base_i_next = vr_i[F:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg <= u_valid;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nu_d_reg[i] <= nu_d_next[i];
                n_d_reg[i]  <= n_l[i];
                u_d_reg[i]  <= u_n[i];
                n_e_reg[i]  <= n_d_reg[i];
                u_e_reg[i]  <= u_d_reg[i];
                m_f_reg[i]  <= m_f_next[i];
                u_f_reg[i]  <= u_e_reg[i];
                r_g_reg[i]  <= r_g_next[i];
                vr_h_reg[i] <= vr_h_next[i];
            end
            dnl_e_reg  <= tmp_e[15 +: DW];
            dnl_f_reg  <= dnl_e_reg;
            dnl_g_reg  <= dnl_f_reg;
            dnl_h_reg  <= dnl_g_reg;
            dnl_i_reg  <= dnl_h_reg;
            base_i_reg <= base_i_next;
            neg_i_reg  <= vr_i < 0;
        end
    end

    // specular power
    logic               p_valid;
    logic [F:0]         power;
    logic [PSIDE_W-1:0] p_side;

    pvl_pow #(
        .FRAC   (F),
        .SIDE_W (PSIDE_W)
    ) u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vi_reg),
        .base      (base_i_reg),
        .shine     (shine_reg),
        .side_in   ({dnl_i_reg, neg_i_reg}),
        .out_valid (p_valid),
        .power     (power),
        .side_out  (p_side)
    );

    // stage j: partial products of the diffuse and specular terms
    logic signed [DW-1:0] dnl_j;
    logic                 vr_neg_j;
    logic [F+1:0]         dnl_pos;
    logic [F:0]           pw_j [3];
    logic [F+17:0]        dlo_next [3], dhi_next [3], dlo_reg [3], dhi_reg [3];
    logic [F+16:0]        slo_next [3], shi_next [3], slo_reg [3], shi_reg [3];
    logic                 vj_reg;

    assign dnl_j    = p_side[PSIDE_W-1:1];
    assign vr_neg_j = p_side[0];
    assign dnl_pos  = (dnl_j < 0) ? '0 : dnl_j[F+1:0];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            // negative n.l with a nonzero diffuse product kills the highlight too
            if (vr_neg_j || ((dnl_j < 0) && (kdil_reg[c] != '0)))
                pw_j[c] = '0;
            else
                pw_j[c] = power;
            dlo_next[c] = kdil_reg[c][15:0]  * dnl_pos;
            dhi_next[c] = kdil_reg[c][31:16] * dnl_pos;
            slo_next[c] = ksil_reg[c][15:0]  * pw_j[c];
            shi_next[c] = ksil_reg[c][31:16] * pw_j[c];
        end
    end

    // stage k: rounded diffuse and specular terms
    logic [F+34:0]     dfull [3], sfull [3];
    logic [TERM_W-1:0] dif_k_reg [3], spc_k_reg [3];
    logic              vk_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dfull[c] = (F+35)'({dhi_reg[c], 16'h0000}) + (F+35)'(dlo_reg[c]) + HALF_K;
            sfull[c] = (F+35)'({shi_reg[c], 16'h0000}) + (F+35)'(slo_reg[c]) + HALF_K;
        end
    end

    // stage l: sum and clamp into the output register
    logic [TOTAL_W-1:0] total [3];
    logic [LANE_W-1:0]  out_next [3], out_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            total[c] = TOTAL_W'(amb_reg[c]) + TOTAL_W'(dif_k_reg[c]) + TOTAL_W'(spc_k_reg[c]);
            if (total[c] > TOTAL_W'(OUT_MAX))
                out_next[c] = OUT_MAX;
            else
                out_next[c] = total[c][LANE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
            vl_reg <= 1'b0;
        end
        else if (en)
        begin
            vj_reg <= p_valid;
            vk_reg <= vj_reg;
            vl_reg <= vk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dlo_reg[c]   <= dlo_next[c];
                dhi_reg[c]   <= dhi_next[c];
                slo_reg[c]   <= slo_next[c];
                shi_reg[c]   <= shi_next[c];
                dif_k_reg[c] <= dfull[c][F+15 +: TERM_W];
                spc_k_reg[c] <= sfull[c][F+15 +: TERM_W];
                out_reg[c]   <= out_next[c];
            end
        end
    end

    assign m_tvalid = vl_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

    // the light vector never exceeds unit length per axis
    a_unit_light: assert property (@(posedge clk) disable iff (!rst_n)
        u_valid |-> (u_n[0] <= ONE_U && u_n[0] >= -ONE_U &&
                     u_n[1] <= ONE_U && u_n[1] >= -ONE_U &&
                     u_n[2] <= ONE_U && u_n[2] >= -ONE_U))
        else $error("light vector component out of range");

    // a base of at most 1.0 keeps the power at or below 1.0
    a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid |-> (power <= ONE_P))
        else $error("specular power above 1.0");

    // clamped channels on every output beat
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] <= OUT_MAX && m_tdata[31:16] <= OUT_MAX &&
                      m_tdata[47:32] <= OUT_MAX))
        else $error("output intensity above 1.0");

    // a beat held at the output freezes the stage behind it
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(vk_reg) && $stable(dif_k_reg[0])))
        else $error("pipeline moved during a stall");

endmodule

// ===== hdl/pvl_norm.sv =====
`timescale 1ns / 1ps
// light vector normalization: pipelined square root of the squared distance,
// then one restoring divider per axis, one quotient bit per stage; uses pvl_pkg
module pvl_norm #(
    parameter int FRAC   = 15,
    parameter int SIDE_W = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [pvl_pkg::SQ_W-1:0]          sq,
    input  logic signed [pvl_pkg::DIFF_W-1:0] d [3],
    input  logic [SIDE_W-1:0]                 side_in,
    output logic                              out_valid,
    output logic signed [FRAC+1:0]            u [3],
    output logic [SIDE_W-1:0]                 side_out
);
    import pvl_pkg::*;

    localparam int WW    = SQ_W + 17;
    localparam int SCW   = 3*MAG_W + 3 + SIDE_W;
    localparam int NSTEP = FRAC + 2;
    localparam int TW    = FRAC + 28;
    localparam int DEN_W = ROOT_W + 1;
    localparam int DCW   = 4 + SIDE_W;
    localparam logic [FRAC+1:0] ONE_Q = (FRAC+2)'(1) << FRAC;

    logic [MAG_W-1:0] mag_in [3];
    logic [2:0]       sgn_in;
    logic [SCW-1:0]   scar_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sgn_in[i] = d[i][DIFF_W-1];
            mag_in[i] = d[i][DIFF_W-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
        end
    end

    assign scar_in = {side_in, sgn_in, mag_in[2], mag_in[1], mag_in[0]};

    // square root, one result bit per stage
    logic [WW-1:0]     srem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sroot_reg [ROOT_W];
    logic              sv_reg    [ROOT_W];
    logic [SCW-1:0]    scar_reg  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - g;
        logic [WW-1:0]     rem_in, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic              v_in;
        logic [SCW-1:0]    car_in;

        if (g == 0)
        begin : g_first
            assign rem_in  = {1'b0, sq, 16'h0000};
            assign root_in = '0;
            assign v_in    = in_valid;
            assign car_in  = scar_in;
        end
        else
        begin : g_rest
            assign rem_in  = srem_reg[g-1];
            assign root_in = sroot_reg[g-1];
            assign v_in    = sv_reg[g-1];
            assign car_in  = scar_reg[g-1];
        end

        assign trial = (WW'(root_in) << (B + 1)) | (WW'(1) << (2*B));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[g] <= 1'b0;
            else if (en)
                sv_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[g]  <= rem_next;
                sroot_reg[g] <= root_next;
                scar_reg[g]  <= car_in;
            end
        end
    end

    // dividers: q = round(mag * 2^(FRAC+8) / len)
    logic [ROOT_W-1:0] len;
    logic [SCW-1:0]    sq_car;
    logic [TW-1:0]     num0 [3];
    logic [DCW-1:0]    dcar_in;

    assign len    = sroot_reg[ROOT_W-1];
    assign sq_car = scar_reg[ROOT_W-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num0[i] = (TW'(sq_car[MAG_W*i +: MAG_W]) << (FRAC + 9)) + TW'(len);
    end

    assign dcar_in = {sq_car[SCW-1 -: SIDE_W], sq_car[3*MAG_W +: 3], len == '0};

    logic [TW-1:0]    drem_reg [NSTEP][3];
    logic [FRAC+1:0]  dq_reg   [NSTEP][3];
    logic [DEN_W-1:0] dden_reg [NSTEP];
    logic             dv_reg   [NSTEP];
    logic [DCW-1:0]   dcar_reg [NSTEP];

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_div
        localparam int K = NSTEP - 1 - j;
        logic [TW-1:0]    rem_in [3];
        logic [TW-1:0]    rem_next [3];
        logic [FRAC+1:0]  q_in [3];
        logic [FRAC+1:0]  q_next [3];
        logic [DEN_W-1:0] den_in;
        logic [TW-1:0]    trial;
        logic             v_in;
        logic [DCW-1:0]   car_in;

        if (j == 0)
        begin : g_first
            assign rem_in = num0;
            assign q_in   = '{default: '0};
            assign den_in = {len, 1'b0};
            assign v_in   = sv_reg[ROOT_W-1];
            assign car_in = dcar_in;
        end
        else
        begin : g_rest
            assign rem_in = drem_reg[j-1];
            assign q_in   = dq_reg[j-1];
            assign den_in = dden_reg[j-1];
            assign v_in   = dv_reg[j-1];
            assign car_in = dcar_reg[j-1];
        end

        assign trial = TW'(den_in) << K;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= trial)
                begin
                    rem_next[i] = rem_in[i] - trial;
                    q_next[i]   = q_in[i] | ((FRAC+2)'(1) << K);
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= 1'b0;
            else if (en)
                dv_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j] <= rem_next;
                dq_reg[j]   <= q_next;
                dden_reg[j] <= den_in;
                dcar_reg[j] <= car_in;
            end
        end
    end

    // clamp to 1.0, restore the sign, zero vector when the light sits on the vertex
    logic [DCW-1:0]         dfin;
    logic signed [FRAC+1:0] mag_q [3];
    logic signed [FRAC+1:0] u_next [3];
    logic                   ov_reg;
    logic signed [FRAC+1:0] u_reg [3];
    logic [SIDE_W-1:0]      side_reg;

    assign dfin = dcar_reg[NSTEP-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_q[i] = (dq_reg[NSTEP-1][i] > ONE_Q) ? ONE_Q : dq_reg[NSTEP-1][i];
            if (dfin[0])
                u_next[i] = '0;
            else if (dfin[1+i])
                u_next[i] = -mag_q[i];
            else
                u_next[i] = mag_q[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_reg[NSTEP-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            side_reg <= dfin[DCW-1 -: SIDE_W];
        end
    end

    assign out_valid = ov_reg;
    assign u         = u_reg;
    assign side_out  = side_reg;

endmodule

// ===== hdl/pvl_pow.sv =====
`timescale 1ns / 1ps
// specular power: square-and-multiply over the exponent bits, msb first,
// at most one rounded product per stage; uses pvl_pkg
module pvl_pow #(
    parameter int FRAC   = 15,
    parameter int SIDE_W = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [FRAC:0]               base,
    input  logic [pvl_pkg::SHINE_W-1:0] shine,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [FRAC:0]               power,
    output logic [SIDE_W-1:0]           side_out
);
    import pvl_pkg::*;

    localparam int NST = 2*SHINE_W;
    localparam logic [FRAC:0]     ONE_P  = (FRAC+1)'(1) << FRAC;
    localparam logic [2*FRAC+2:0] HALF_P = (2*FRAC+3)'(1) << (FRAC - 1);

    logic [FRAC:0]       acc_reg  [NST];
    logic [FRAC:0]       base_reg [NST];
    logic                v_reg    [NST];
    logic [SIDE_W-1:0]   car_reg  [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_step
        localparam int BIT    = SHINE_W - 1 - s/2;
        localparam bit IS_MUL = (s % 2) == 1;
        logic [FRAC:0]       acc_in, base_in, op, acc_next;
        logic [2*FRAC+1:0]   prod;
        logic [2*FRAC+2:0]   rnd;
        logic                v_in;
        logic [SIDE_W-1:0]   car_in;

        if (s == 0)
        begin : g_first
            assign acc_in  = ONE_P;
            assign base_in = base;
            assign v_in    = in_valid;
            assign car_in  = side_in;
        end
        else
        begin : g_rest
            assign acc_in  = acc_reg[s-1];
            assign base_in = base_reg[s-1];
            assign v_in    = v_reg[s-1];
            assign car_in  = car_reg[s-1];
        end

        // even stages square, odd stages multiply by the base when the bit is set
        assign op   = IS_MUL ? base_in : acc_in;
        assign prod = acc_in * op;
        assign rnd  = (2*FRAC+3)'(prod) + HALF_P;

        always_comb
        begin
            if (IS_MUL && !shine[BIT])
                acc_next = acc_in;
            else
                acc_next = rnd[FRAC +: FRAC+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s]  <= acc_next;
                base_reg[s] <= base_in;
                car_reg[s]  <= car_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign power     = acc_reg[NST-1];
    assign side_out  = car_reg[NST-1];

endmodule
